// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define QTG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qtg assertion failed");
`define QTG_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("qtg forbidden condition seen");
`else
`define QTG_ASSERT(lbl, clk, rst_n, prop)
`define QTG_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hdl/qtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_pkg
// Shared types, constants and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package qtg_pkg;

    localparam int POS_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int DUR_W     = 33;
    localparam int TSTEP_W   = 16;
    localparam logic [TSTEP_W-1:0] TSTEP_RESET = 16'd524;
    localparam int FIFO_DEPTH = 2;
    localparam int MUL_STEPS  = 4;
    localparam int DIV_BITS   = POS_W + FRAC_BITS;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // one tick request as handed from front to back
    typedef struct packed {
        logic signed [POS_W-1:0] target_position;
        logic signed [POS_W-1:0] target_velocity;
        logic signed [POS_W-1:0] start_accel;
        logic signed [POS_W-1:0] end_accel;
        logic signed [DUR_W-1:0] dur;
        logic [POS_W-1:0]        etime;
        logic                    calc;
        logic                    moving;
        logic                    restarted;
        logic                    bad;
    } t_item;

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] f_sneg(input logic signed [63:0] a);
        return (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    // halve, truncating toward zero
    function automatic logic signed [63:0] f_half(input logic signed [63:0] a);
        logic signed [63:0] t;
        t = a + {63'd0, a[63]};
        return t >>> 1;
    endfunction

    function automatic logic [POS_W-1:0] f_clamp(input logic signed [63:0] a);
        if (a > 64'sh0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
        if (a < -64'sh0000_0000_8000_0000) return 32'h8000_0000;
        return a[POS_W-1:0];
    endfunction

endpackage

// ===== hdl/qtg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_front
// Accepts ticks, detects target changes, advances elapsed time, classifies.
// ----------------------------------------------------------------------------
module qtg_front import qtg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [TSTEP_W-1:0]      i_cfg_wdata,
    input  logic                    i_push,
    input  logic                    i_full,
    input  logic signed [POS_W-1:0] i_target_position,
    input  logic signed [POS_W-1:0] i_target_velocity,
    input  logic signed [POS_W-1:0] i_start_accel,
    input  logic signed [POS_W-1:0] i_end_accel,
    input  logic [POS_W-1:0]        i_start_time,
    input  logic [POS_W-1:0]        i_end_time,
    output logic                    o_push,
    output t_item                   o_item
);

    logic [TSTEP_W-1:0]      r_time_step;
    logic [POS_W-1:0]        r_elapsed;
    logic signed [POS_W-1:0] r_last_pos;
    logic signed [POS_W-1:0] r_last_vel;
    logic [POS_W-1:0]        r_last_end;

    logic              chg;
    logic [POS_W-1:0]  el0;
    logic [POS_W:0]    el_sum;
    logic [POS_W-1:0]  el_new;
    logic              calc;
    logic [DUR_W-1:0]  d;

    // classification of the incoming tick
    always_comb begin
        chg    = (i_target_position != r_last_pos) || (i_target_velocity != r_last_vel)
                 || (i_end_time != r_last_end);
        el0    = chg ? '0 : r_elapsed;
        calc   = (el0 == '0);
        el_sum = {1'b0, el0} + {{(POS_W+1-TSTEP_W){1'b0}}, r_time_step};
        el_new = el_sum[POS_W] ? '1 : el_sum[POS_W-1:0];
        d      = {1'b0, i_end_time} - {1'b0, i_start_time};
        o_push = i_push && !i_full;
        o_item.target_position = i_target_position;
        o_item.target_velocity = i_target_velocity;
        o_item.start_accel     = i_start_accel;
        o_item.end_accel       = i_end_accel;
        o_item.dur             = d;
        o_item.etime           = el_new;
        o_item.calc            = calc;
        o_item.moving          = !(el_new > i_end_time);
        o_item.restarted       = chg;
        o_item.bad             = d[DUR_W-1] || (d == '0);
    end

    // segment tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TSTEP_RESET;
            r_elapsed   <= '0;
            r_last_pos  <= '0;
            r_last_vel  <= '0;
            r_last_end  <= '0;
        end else begin
            if (i_cfg_we) r_time_step <= i_cfg_wdata;
            if (o_push) begin
                r_elapsed <= el_new;
                if (calc) begin
                    r_last_pos <= i_target_position;
                    r_last_vel <= i_target_velocity;
                    r_last_end <= i_end_time;
                end
            end
        end
    end

endmodule

// ===== hdl/qtg_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module qtg_fifo import qtg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PW = $clog2(FIFO_DEPTH);

    t_item          r_mem [FIFO_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_count;

    assign o_full  = (r_count == FIFO_DEPTH[PW:0]);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ===== hdl/qtg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_mul
// Saturating signed Q multiply, 64x64 over four 32x32 partial products.
// ----------------------------------------------------------------------------
module qtg_mul import qtg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    logic         r_busy;
    logic [2:0]   r_step;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [127:0] r_acc;
    logic         r_done;
    logic signed [63:0] r_res;

    logic [31:0]  ah;
    logic [31:0]  bh;
    logic [63:0]  pp;
    logic [127:0] pp_ext;
    logic [47:0]  hi;
    logic [63:0]  lo;
    logic [63:0]  limit;
    logic         sat;

    assign o_done = r_done;
    assign o_res  = r_res;

    // partial product and final scaling
    always_comb begin
        ah = r_step[1] ? r_ua[63:32] : r_ua[31:0];
        bh = r_step[0] ? r_ub[63:32] : r_ub[31:0];
        pp = ah * bh;
        unique case ({1'b0, r_step[1]} + {1'b0, r_step[0]})
            2'd0:    pp_ext = {64'd0, pp};
            2'd1:    pp_ext = {32'd0, pp, 32'd0};
            default: pp_ext = {pp, 64'd0};
        endcase
        hi    = r_acc[127:80];
        lo    = r_acc[79:16];
        limit = r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        sat   = (hi != '0) || (lo > limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_ua   <= i_a[63] ? 64'd0 - i_a : i_a;
                r_ub   <= i_b[63] ? 64'd0 - i_b : i_b;
                r_neg  <= i_a[63] != i_b[63];
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_step == 3'(MUL_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_neg) r_res <= sat ? S64_MIN : -$signed(lo);
                    else       r_res <= sat ? S64_MAX : $signed(lo);
                end else begin
                    r_acc  <= r_acc + pp_ext;
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/qtg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtg_div
// Restoring divider, one quotient bit per cycle: (t << FRAC) / d.
// ----------------------------------------------------------------------------
module qtg_div import qtg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [POS_W-1:0]    i_num,
    input  logic [POS_W-1:0]    i_den,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quo
);

    localparam int CW = $clog2(DIV_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [POS_W:0]      r_rem;
    logic [DIV_BITS-1:0] r_q;
    logic [POS_W-1:0]    r_den;

    logic [POS_W+1:0]    rem_sh;
    logic [POS_W+1:0]    diff;
    logic                ge;

    assign o_done = r_done;
    assign o_quo  = r_q;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem, r_q[DIV_BITS-1]};
        diff   = rem_sh - {2'b00, r_den};
        ge     = rem_sh >= {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= {i_num, {FRAC_BITS{1'b0}}};
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[POS_W:0] : rem_sh[POS_W:0];
                r_q   <= {r_q[DIV_BITS-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/qtg_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// qtg_back
// Sequencer: quintic coefficients, polynomial evaluation, result register.
// ----------------------------------------------------------------------------
module qtg_back import qtg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_item             i_item,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [POS_W-1:0]  o_position,
    output logic              o_moving,
    output logic              o_restarted,
    output logic              o_bad_duration
);

    localparam logic [4:0] S_IDLE = 5'd0,  S_VD  = 5'd1,  S_DD  = 5'd2,  S_M3  = 5'd3,
                           S_M4   = 5'd4,  S_M5  = 5'd5,  S_TT  = 5'd6,  S_C2T = 5'd7,
                           S_DIV  = 5'd8,  S_S2  = 5'd9,  S_S3  = 5'd10, S_C3T = 5'd11,
                           S_S4   = 5'd12, S_C4T = 5'd13, S_S5  = 5'd14, S_C5T = 5'd15,
                           S_OUT  = 5'd16;

    logic [4:0]              r_state;
    logic                    r_wait;
    logic signed [POS_W-1:0] r_vf;
    logic signed [POS_W-1:0] r_ai;
    logic signed [POS_W-1:0] r_af;
    logic signed [DUR_W-1:0] r_d;
    logic signed [DUR_W:0]   r_dp;
    logic [POS_W-1:0]        r_t;
    logic                    r_moving;
    logic                    r_restarted;
    logic                    r_bad;
    logic signed [63:0]      r_vd;
    logic signed [63:0]      r_dd;
    logic signed [63:0]      r_pw;
    logic signed [63:0]      r_s;
    logic signed [63:0]      r_acc;
    logic signed [63:0]      r_c0;
    logic signed [63:0]      r_c2;
    logic signed [63:0]      r_c3;
    logic signed [63:0]      r_c4;
    logic signed [63:0]      r_c5;
    logic signed [DUR_W-1:0] r_dur;
    logic [POS_W-1:0]        r_cur;
    logic                    r_out_valid;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_moving;
    logic                    r_out_restarted;
    logic                    r_out_bad;

    logic signed [63:0] vf64, ai64, af64, d64, dp64;
    logic signed [63:0] lin3, lin4, lin5;
    logic signed [63:0] mul_a, mul_b, mul_res;
    logic               is_mul, mul_start, mul_done;
    logic               div_start, div_done;
    logic [DIV_BITS-1:0] div_q;
    logic               dur_pos;
    logic               out_free;
    logic               out_hold;
    logic [POS_W-1:0]   pos_next;

    // operand widening and the cheap constant-multiple terms
    always_comb begin
        vf64 = 64'(r_vf);
        ai64 = 64'(r_ai);
        af64 = 64'(r_af);
        d64  = 64'(r_d);
        dp64 = 64'(r_dp);
        lin3 = dp64 * 64'sd20 - r_vd * 64'sd8;
        lin4 = r_vd * 64'sd14 - dp64 * 64'sd30;
        lin5 = dp64 * 64'sd12 - r_vd * 64'sd6;
        dur_pos  = !r_dur[DUR_W-1] && (r_dur != '0);
        out_free = !r_out_valid || i_pop;
        out_hold = (r_state == S_OUT) && out_free && !r_moving;
        pos_next = r_moving ? f_clamp(r_acc) : r_cur;
    end

    // multiplier operand selection, unit start strobes and queue pop
    always_comb begin
        is_mul = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_VD:  begin mul_a = vf64;                          mul_b = d64;  end
            S_DD:  begin mul_a = d64;                           mul_b = d64;  end
            S_M3:  begin mul_a = af64 * 64'sd3 - ai64;          mul_b = r_dd; end
            S_M4:  begin mul_a = af64 * 64'sd3 - ai64 * 64'sd2; mul_b = r_dd; end
            S_M5:  begin mul_a = af64 - ai64;                   mul_b = r_dd; end
            S_TT:  begin mul_a = {32'd0, r_t};                  mul_b = {32'd0, r_t}; end
            S_C2T: begin mul_a = r_c2;                          mul_b = r_pw; end
            S_S2:  begin mul_a = r_s;                           mul_b = r_s;  end
            S_S3, S_S4, S_S5: begin mul_a = r_pw;               mul_b = r_s;  end
            S_C3T: begin mul_a = r_c3;                          mul_b = r_pw; end
            S_C4T: begin mul_a = r_c4;                          mul_b = r_pw; end
            S_C5T: begin mul_a = r_c5;                          mul_b = r_pw; end
            default: is_mul = 1'b0;
        endcase
        mul_start = is_mul && !r_wait;
        div_start = (r_state == S_DIV) && !r_wait;
        o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    end

    qtg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    qtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_t),
        .i_den   (r_dur[POS_W-1:0]),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_dur       <= '0;
            r_c0        <= '0;
            r_c2        <= '0;
            r_c3        <= '0;
            r_c4        <= '0;
            r_c5        <= '0;
        end else begin
            if (mul_start || div_start)  r_wait <= 1'b1;
            else if (mul_done || div_done) r_wait <= 1'b0;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (i_pop)                   r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_vf        <= i_item.target_velocity;
                        r_ai        <= i_item.start_accel;
                        r_af        <= i_item.end_accel;
                        r_d         <= i_item.dur;
                        r_dp        <= {{2{i_item.target_position[POS_W-1]}},
                                        i_item.target_position}
                                       - {{2{r_cur[POS_W-1]}}, r_cur};
                        r_t         <= i_item.etime;
                        r_moving    <= i_item.moving;
                        r_restarted <= i_item.restarted;
                        r_bad       <= i_item.bad;
                        if (i_item.calc) begin
                            r_c0  <= 64'($signed(r_cur));
                            r_c2  <= i_item.bad ? '0 : f_half(64'(i_item.start_accel));
                            r_c3  <= '0;
                            r_c4  <= '0;
                            r_c5  <= '0;
                            r_dur <= i_item.dur;
                        end
                        if (i_item.calc && !i_item.bad) r_state <= S_VD;
                        else if (i_item.moving)         r_state <= S_TT;
                        else                            r_state <= S_OUT;
                    end
                end
                S_VD: if (mul_done) begin
                    r_vd <= mul_res;  r_state <= S_DD;
                end
                S_DD: if (mul_done) begin
                    r_dd <= mul_res;  r_state <= S_M3;
                end
                S_M3: if (mul_done) begin
                    r_c3 <= f_half(f_sadd(lin3, f_sneg(mul_res)));  r_state <= S_M4;
                end
                S_M4: if (mul_done) begin
                    r_c4 <= f_half(f_sadd(lin4, mul_res));  r_state <= S_M5;
                end
                S_M5: if (mul_done) begin
                    r_c5    <= f_half(f_sadd(lin5, f_sneg(mul_res)));
                    r_state <= r_moving ? S_TT : S_OUT;
                end
                S_TT: if (mul_done) begin
                    r_pw <= mul_res;  r_state <= S_C2T;
                end
                S_C2T: if (mul_done) begin
                    r_acc   <= f_sadd(r_c0, mul_res);
                    r_state <= dur_pos ? S_DIV : S_OUT;
                end
                S_DIV: if (div_done) begin
                    r_s <= {{(64-DIV_BITS){1'b0}}, div_q};  r_state <= S_S2;
                end
                S_S2: if (mul_done) begin
                    r_pw <= mul_res;  r_state <= S_S3;
                end
                S_S3: if (mul_done) begin
                    r_pw <= mul_res;  r_state <= S_C3T;
                end
                S_C3T: if (mul_done) begin
                    r_acc <= f_sadd(r_acc, mul_res);  r_state <= S_S4;
                end
                S_S4: if (mul_done) begin
                    r_pw <= mul_res;  r_state <= S_C4T;
                end
                S_C4T: if (mul_done) begin
                    r_acc <= f_sadd(r_acc, mul_res);  r_state <= S_S5;
                end
                S_S5: if (mul_done) begin
                    r_pw <= mul_res;  r_state <= S_C5T;
                end
                S_C5T: if (mul_done) begin
                    r_acc <= f_sadd(r_acc, mul_res);  r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_cur   <= pos_next;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_pos       <= pos_next;
            r_out_moving    <= r_moving;
            r_out_restarted <= r_restarted;
            r_out_bad       <= r_bad;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_position     = r_out_pos;
    assign o_moving       = r_out_moving;
    assign o_restarted    = r_out_restarted;
    assign o_bad_duration = r_out_bad;

    `QTG_ASSERT(a_done_while_wait, i_clk, i_rst_n, (mul_done || div_done) |-> r_wait)
    `QTG_NEVER(a_idle_no_wait, i_clk, i_rst_n, (r_state == S_IDLE) && r_wait)
    `QTG_ASSERT(a_hold_keeps_pos, i_clk, i_rst_n, out_hold |=> (r_cur == $past(r_cur)))

endmodule

// ===== hdl/quintic_trajectory_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_core
// Quintic position trajectory, one result per control tick.
// ----------------------------------------------------------------------------
// One tick goes in, one commanded position comes out, in order. A tick that
// only holds position goes from the idle state straight to the output state
// in the back end; a tick that also computes coefficients adds 5 multiplies,
// and a moving tick with a positive duration needs 9 multiplies plus one
// 48-bit division. The multiplies run on the single shared 64x64 multiplier
// (four 32x32 partial products, one per cycle) and the division runs on the
// bit-serial divider. A two-entry queue between the front end and the
// sequencer and a one-entry result register let the input side and the
// result side stall independently. Write time_step only while the block is
// idle.
module quintic_trajectory_generator_core import qtg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [TSTEP_W-1:0]      i_cfg_wdata,
    input  logic                    push,
    output logic                    full,
    input  logic signed [POS_W-1:0] i_target_position,
    input  logic signed [POS_W-1:0] i_target_velocity,
    input  logic signed [POS_W-1:0] i_start_accel,
    input  logic signed [POS_W-1:0] i_end_accel,
    input  logic [POS_W-1:0]        i_start_time,
    input  logic [POS_W-1:0]        i_end_time,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [POS_W-1:0] o_position,
    output logic                    o_moving,
    output logic                    o_restarted,
    output logic                    o_bad_duration
);

    logic  f_push;
    t_item f_item;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    t_item q_item;
    logic [POS_W-1:0] pos;

    assign full       = q_full;
    assign o_position = $signed(pos);

    qtg_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_push            (push),
        .i_full            (q_full),
        .i_target_position (i_target_position),
        .i_target_velocity (i_target_velocity),
        .i_start_accel     (i_start_accel),
        .i_end_accel       (i_end_accel),
        .i_start_time      (i_start_time),
        .i_end_time        (i_end_time),
        .o_push            (f_push),
        .o_item            (f_item)
    );

    qtg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    qtg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_item         (q_item),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_position     (pos),
        .o_moving       (o_moving),
        .o_restarted    (o_restarted),
        .o_bad_duration (o_bad_duration)
    );

endmodule
